/* design/assert_macros.svh */
// Assertion macros for the cell buffer checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an antecedent implies a consequent in the same cycle
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// Check that an antecedent implies a consequent in the next cycle
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

/* design/tmcb_pkg.sv */
// Package: payload types and constants for the text cell buffer
`default_nettype none
package tmcb_pkg;
	localparam int unsigned DEF_COLUMNS = 80;
	localparam int unsigned DEF_ROWS    = 25;
	localparam logic [7:0]  SPACE_CHAR  = 8'h20;

	localparam logic [2:0] OP_WRITE = 3'd0;
	localparam logic [2:0] OP_READ  = 3'd1;
	localparam logic [2:0] OP_ATTR  = 3'd2;
	localparam logic [2:0] OP_SUP   = 3'd3;
	localparam logic [2:0] OP_SDN   = 3'd4;
	localparam logic [2:0] OP_CLEAR = 3'd5;

	typedef struct packed {
		logic [2:0] opcode;
		logic [5:0] row;
		logic [6:0] col;
		logic [7:0] character;
		logic [7:0] attribute;
		logic [6:0] count;
		logic [5:0] last_row;
	} tmcb_req_t;

	typedef struct packed {
		logic [7:0] cell_character;
		logic [7:0] cell_attribute;
		logic       status;
	} tmcb_rsp_t;
endpackage
`default_nettype wire

/* design/text_mode_cell_buffer_top.sv */
// Top level: text cell screen store with run recolor, window scroll and clear
// One request a word. Write is an accept, then a memory write; read is an
// accept, a memory read and a result capture. Attribute run is an accept,
// then a read and a write back for each cell touched.
// Scroll walks the window row by row and column by column: a read of the
// source and a write of the target for each moved cell, one write for each
// filled cell. Clear writes each cell in turn. The next request is accepted
// once the result word has been taken. After reset a clearing pass over all
// ROWS*COLUMNS cells fills the screen with spaces before the first request
// is accepted.
`default_nettype none
module text_mode_cell_buffer_top
	import tmcb_pkg::*;
#(
	parameter int unsigned COLUMNS = DEF_COLUMNS,
	parameter int unsigned ROWS    = DEF_ROWS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire tmcb_req_t in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output tmcb_rsp_t      out_data
);
	localparam int unsigned DEPTH = ROWS * COLUMNS;
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_WR   = 3'd3;
	localparam logic [2:0] ST_FILL = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;
	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic [15:0] wdata;
	logic        re;

	logic [2:0]    state_q;
	tmcb_req_t     req_q;
	logic [RW-1:0] r_q;     // current target row
	logic [CW-1:0] c_q;     // current column
	logic [RW-1:0] stop_q;  // last row of the copy phase
	logic [6:0]    cend_q;  // last column of run
	logic [AW-1:0] addr_q;
	logic          dir_q;   // 1: scroll down
	logic          copy_q;  // copy phase active
	tmcb_rsp_t     rsp_q;
	logic          ovalid_q;

	wire [6:0] rowx = {1'b0, in_data.row};
	wire [6:0] botx = {1'b0, in_data.last_row};
	wire pos_ok = ({1'b0, in_data.row} < 7'(ROWS)) && ({1'b0, in_data.col} < 8'(COLUMNS));
	wire win_ok = (botx < 7'(ROWS)) && (rowx <= botx) && (in_data.count != 7'd0);
	wire [7:0] hgt = 8'(botx) - 8'(rowx) + 8'd1;
	wire ovs = {1'b0, in_data.count} >= hgt;
	wire is_scroll = (in_data.opcode == OP_SUP) || (in_data.opcode == OP_SDN);
	wire is_sdn = (in_data.opcode == OP_SDN);
	wire [RW-1:0] start_row = is_sdn ? RW'(in_data.last_row) : RW'(in_data.row);
	wire [CW-1:0] start_col = is_scroll ? '0 : CW'(in_data.col);

	assign in_stall = (state_q != ST_IDLE) || ovalid_q;
	wire acc = in_valid && !in_stall;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
		logic [AW+CW-1:0] p;
		p = (AW+CW)'(r) * (AW+CW)'(COLUMNS) + (AW+CW)'(c);
		return p[AW-1:0];
	endfunction

	wire last_col = ({1'b0, c_q} == (CW+1)'(COLUMNS - 1));
	// source row of copy for current target row
	wire [RW-1:0] src_row = dir_q ? RW'(r_q - RW'(req_q.count)) : RW'(r_q + RW'(req_q.count));

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_comb begin
		we = 1'b0; waddr = addr_q; wdata = {8'h00, SPACE_CHAR};
		re = 1'b0; raddr = addr_q;
		unique case (state_q)
			ST_INIT: begin
				we = 1'b1;
			end
			ST_RD: begin
				re = 1'b1;
				raddr = copy_q ? cell_addr(src_row, c_q) : addr_q;
			end
			ST_WR: begin
				we = 1'b1;
				if (req_q.opcode == OP_WRITE) wdata = {req_q.attribute, req_q.character};
				else if (req_q.opcode == OP_ATTR) wdata = {req_q.attribute, rdata_q[7:0]};
				else wdata = rdata_q;
			end
			ST_FILL: begin
				we = 1'b1;
				wdata = {req_q.attribute, SPACE_CHAR};
			end
			default: ;
		endcase
	end

	assign out_valid = ovalid_q;
	assign out_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			addr_q   <= '0;
			ovalid_q <= 1'b0;
			req_q    <= '0;
			r_q <= '0; c_q <= '0; stop_q <= '0; cend_q <= '0;
			dir_q <= 1'b0; copy_q <= 1'b0; rsp_q <= '0;
		end else begin
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					if ({1'b0, addr_q} == (AW+1)'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
					addr_q <= addr_q + 1'b1;
				end
				ST_IDLE: if (acc) begin
					req_q  <= in_data;
					copy_q <= is_scroll && !ovs;
					dir_q  <= is_sdn;
					c_q    <= start_col;
					r_q    <= start_row;
					stop_q <= is_sdn ? RW'(rowx + 7'(in_data.count)) :
						RW'(botx - 7'(in_data.count));
					addr_q <= (in_data.opcode == OP_CLEAR) ? '0 :
						cell_addr(start_row, start_col);
					cend_q <= ((8'(in_data.col) + 8'(in_data.count)) > 8'(COLUMNS)) ?
						7'(COLUMNS - 1) : 7'(8'(in_data.col) + 8'(in_data.count) - 8'd1);
					unique case (in_data.opcode) inside
						OP_WRITE: begin
							rsp_q <= '{8'h00, 8'h00, !pos_ok};
							if (pos_ok) state_q <= ST_WR;
							else ovalid_q <= 1'b1;
						end
						OP_READ: begin
							if (pos_ok) begin
								rsp_q <= '0;
								state_q <= ST_RD;
							end else begin
								rsp_q <= '{SPACE_CHAR, 8'h00, 1'b1};
								ovalid_q <= 1'b1;
							end
						end
						OP_ATTR: begin
							rsp_q <= '{8'h00, 8'h00, !pos_ok};
							if (pos_ok && in_data.count != 7'd0) state_q <= ST_RD;
							else ovalid_q <= 1'b1;
						end
						OP_SUP, OP_SDN: begin
							rsp_q <= '{8'h00, 8'h00, !win_ok};
							if (win_ok) state_q <= ovs ? ST_FILL : ST_RD;
							else ovalid_q <= 1'b1;
						end
						OP_CLEAR: begin
							rsp_q <= '0;
							state_q <= ST_FILL;
						end
						default: begin
							rsp_q <= '{8'h00, 8'h00, 1'b1};
							ovalid_q <= 1'b1;
						end
					endcase
				end
				ST_RD: state_q <= (req_q.opcode == OP_READ) ? ST_DONE : ST_WR;
				ST_WR: begin
					if (req_q.opcode == OP_WRITE) begin
						ovalid_q <= 1'b1; state_q <= ST_IDLE;
					end else if (req_q.opcode == OP_ATTR) begin
						if ({1'b0, c_q} == (CW+1)'(cend_q)) begin
							ovalid_q <= 1'b1; state_q <= ST_IDLE;
						end else begin
							c_q <= c_q + 1'b1; addr_q <= addr_q + 1'b1; state_q <= ST_RD;
						end
					end else begin
						// scroll copy step
						if (!last_col) begin
							c_q <= c_q + 1'b1; addr_q <= addr_q + 1'b1; state_q <= ST_RD;
						end else begin
							c_q <= '0;
							if (r_q == stop_q) begin
								copy_q <= 1'b0;
								r_q <= dir_q ? RW'(r_q - 1'b1) : RW'(r_q + 1'b1);
								addr_q <= cell_addr(dir_q ? RW'(r_q - 1'b1) :
									RW'(r_q + 1'b1), '0);
								state_q <= ST_FILL;
							end else begin
								r_q <= dir_q ? RW'(r_q - 1'b1) : RW'(r_q + 1'b1);
								addr_q <= cell_addr(dir_q ? RW'(r_q - 1'b1) :
									RW'(r_q + 1'b1), '0);
								state_q <= ST_RD;
							end
						end
					end
				end
				ST_FILL: begin
					if (req_q.opcode == OP_CLEAR) begin
						addr_q <= addr_q + 1'b1;
						if ({1'b0, addr_q} == (AW+1)'(DEPTH - 1)) begin
							ovalid_q <= 1'b1; state_q <= ST_IDLE;
						end
					end else if (!last_col) begin
						c_q <= c_q + 1'b1; addr_q <= addr_q + 1'b1;
					end else begin
						c_q <= '0;
						if ((!dir_q && r_q == RW'(req_q.last_row)) ||
							(dir_q && r_q == RW'(req_q.row))) begin
							ovalid_q <= 1'b1; state_q <= ST_IDLE;
						end else begin
							r_q <= dir_q ? RW'(r_q - 1'b1) : RW'(r_q + 1'b1);
							addr_q <= cell_addr(dir_q ? RW'(r_q - 1'b1) :
								RW'(r_q + 1'b1), '0);
						end
					end
				end
				ST_DONE: begin
					rsp_q.cell_character <= rdata_q[7:0];
					rsp_q.cell_attribute <= rdata_q[15:8];
					ovalid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* design/tmcb_checker.sv */
// Checker: port-level properties of the text cell buffer
`default_nettype none
`include "assert_macros.svh"
module tmcb_checker
	import tmcb_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire tmcb_req_t in_data,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire tmcb_rsp_t out_data
);
	wire bad_op_acc = in_valid && !in_stall && (in_data.opcode > OP_CLEAR);

	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`CHK_IMPL(a_busy_out, clk, arst_n, out_valid, in_stall)
	`CHK_NEXT(a_bad_op, clk, arst_n, bad_op_acc, out_valid && out_data.status)
	`CHK_NEXT(a_one_word, clk, arst_n, in_valid && !in_stall, in_stall)
endmodule

bind text_mode_cell_buffer_top tmcb_checker u_tmcb_checker (.*);
`default_nettype wire
